>>> src/gdr_pkg.sv
// Shared constants and types for the gamepad debounce and report block.
package gdr_pkg;

  localparam int BUTTONS_PER_PAD = 8;
  localparam int MAX_PADS = 4;
  localparam int PAD_COUNT_DEFAULT = 4;
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [7:0] THRESHOLD_RESET = 8'd10;

  localparam int BTN_A = 0;
  localparam int BTN_B = 1;
  localparam int BTN_SELECT = 2;
  localparam int BTN_START = 3;
  localparam int BTN_UP = 4;
  localparam int BTN_DOWN = 5;
  localparam int BTN_LEFT = 6;
  localparam int BTN_RIGHT = 7;

  localparam logic signed [7:0] AXIS_POS = 8'sd127;
  localparam logic signed [7:0] AXIS_NEG = -8'sd127;
  localparam logic signed [7:0] AXIS_ZERO = 8'sd0;

  localparam int KIND_SCAN = 0;
  localparam int KIND_REPORT = 1;

  typedef struct packed {
    logic [1:0]        pad_index;
    logic [3:0]        button_mask;
    logic signed [7:0] axis_x;
    logic signed [7:0] axis_y;
    logic              changed;
  } report_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] pad;
  } report_req_t;

endpackage

>>> src/gdr_lane.sv
// Debounce lane for the eight buttons of one pad.
module gdr_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  scan_en,
  input  logic [gdr_pkg::BUTTONS_PER_PAD-1:0]   pins,
  input  logic [7:0]                            threshold,
  output logic [gdr_pkg::BUTTONS_PER_PAD-1:0]   pressed
);

  logic [gdr_pkg::CNT_W-1:0] counter [gdr_pkg::BUTTONS_PER_PAD];

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed <= '0;
      for (int b = 0; b < gdr_pkg::BUTTONS_PER_PAD; b++) begin
        counter[b] <= '0;
      end
    end else if (scan_en) begin
      for (int b = 0; b < gdr_pkg::BUTTONS_PER_PAD; b++) begin
        if (!pins[b] != pressed[b]) begin
          if (counter[b] > threshold) begin
            pressed[b] <= !pins[b];
            counter[b] <= '0;
          end else if (counter[b] != gdr_pkg::CNT_MAX) begin
            counter[b] <= counter[b] + 1'b1;
          end
        end else begin
          counter[b] <= '0;
        end
      end
    end
  end

endmodule

>>> src/gdr_report.sv
// Report builder with per-pad previous report store and skid output stage.
module gdr_report #(
  parameter int PAD_COUNT = gdr_pkg::PAD_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gdr_pkg::report_req_t                req,
  input  logic [gdr_pkg::BUTTONS_PER_PAD-1:0] buttons,
  output logic                                req_ready,
  output logic                                rpt_valid,
  input  logic                                rpt_ready,
  output gdr_pkg::report_t                    rpt
);

  localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  logic [19:0]      prev [PAD_COUNT];
  logic [3:0]       mask;
  logic signed [7:0] ax;
  logic signed [7:0] ay;
  logic [19:0]      packed_rpt;
  gdr_pkg::report_t new_rpt;
  gdr_pkg::report_t skid;
  logic             skid_valid;

  always_comb begin
    mask = {buttons[gdr_pkg::BTN_START], buttons[gdr_pkg::BTN_SELECT],
            buttons[gdr_pkg::BTN_B], buttons[gdr_pkg::BTN_A]};
    if (buttons[gdr_pkg::BTN_UP]) begin
      ay = gdr_pkg::AXIS_POS;
    end else if (buttons[gdr_pkg::BTN_DOWN]) begin
      ay = gdr_pkg::AXIS_NEG;
    end else begin
      ay = gdr_pkg::AXIS_ZERO;
    end
    if (buttons[gdr_pkg::BTN_LEFT]) begin
      ax = gdr_pkg::AXIS_NEG;
    end else if (buttons[gdr_pkg::BTN_RIGHT]) begin
      ax = gdr_pkg::AXIS_POS;
    end else begin
      ax = gdr_pkg::AXIS_ZERO;
    end
    packed_rpt = {ay, ax, mask};
    new_rpt.pad_index = req.pad;
    new_rpt.button_mask = mask;
    new_rpt.axis_x = ax;
    new_rpt.axis_y = ay;
    new_rpt.changed = (packed_rpt != prev[req.pad[PAD_W-1:0]]);
  end

  assign req_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        prev[p] <= '0;
      end
    end else if (req.valid) begin
      prev[req.pad[PAD_W-1:0]] <= packed_rpt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rpt_valid || rpt_ready) begin
      if (skid_valid) begin
        rpt <= skid;
        rpt_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (req.valid) begin
        rpt <= new_rpt;
        rpt_valid <= 1'b1;
      end else begin
        rpt_valid <= 1'b0;
      end
    end else if (req.valid) begin
      skid <= new_rpt;
      skid_valid <= 1'b1;
    end
  end

endmodule

>>> src/gamepad_debounce_report.sv
// Top level: debounced buttons and per-pad reports for serially read gamepads.
// A scan item updates all button lanes in the cycle it is accepted.
// A report item is registered to the output, or to the skid on a sink stall.
// One item is accepted per cycle while the two-entry output stage has room.
// Reset releases all buttons, clears counters and previous reports, threshold 10.
module gamepad_debounce_report #(
  parameter int PAD_COUNT = gdr_pkg::PAD_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [7:0]        pad0_pins,
  input  logic [7:0]        pad1_pins,
  input  logic [7:0]        pad2_pins,
  input  logic [7:0]        pad3_pins,
  input  logic [1:0]        pad_select,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        pad_index,
  output logic [3:0]        button_mask,
  output logic signed [7:0] axis_x,
  output logic signed [7:0] axis_y,
  output logic              changed
);

  logic [7:0]                            threshold;
  logic [gdr_pkg::BUTTONS_PER_PAD-1:0]   pins [gdr_pkg::MAX_PADS];
  logic [gdr_pkg::BUTTONS_PER_PAD-1:0]   pressed [gdr_pkg::MAX_PADS];
  logic                                  accept;
  logic                                  scan_en;
  gdr_pkg::report_req_t                  req;
  gdr_pkg::report_t                      rpt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gdr_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  assign pins[0] = pad0_pins;
  assign pins[1] = pad1_pins;
  assign pins[2] = pad2_pins;
  assign pins[3] = pad3_pins;

  assign accept = in_valid && in_ready;
  assign scan_en = accept && (kind == 1'(gdr_pkg::KIND_SCAN));

  for (genvar p = 0; p < gdr_pkg::MAX_PADS; p++) begin : g_pad
    if (p < PAD_COUNT) begin : g_lane
      gdr_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .scan_en   (scan_en),
        .pins      (pins[p]),
        .threshold (threshold),
        .pressed   (pressed[p])
      );
    end else begin : g_none
      assign pressed[p] = '0;
    end
  end

  assign req.valid = accept && (kind == 1'(gdr_pkg::KIND_REPORT))
                     && (32'(pad_select) < PAD_COUNT);
  assign req.pad = pad_select;

  gdr_report #(
    .PAD_COUNT (PAD_COUNT)
  ) u_report (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .buttons   (pressed[pad_select]),
    .req_ready (in_ready),
    .rpt_valid (out_valid),
    .rpt_ready (out_ready),
    .rpt       (rpt)
  );

  assign pad_index = rpt.pad_index;
  assign button_mask = rpt.button_mask;
  assign axis_x = rpt.axis_x;
  assign axis_y = rpt.axis_y;
  assign changed = rpt.changed;

endmodule
